// ===== sv/pci_pkg.sv =====
`default_nettype none

package pci_pkg;

    localparam int X_SYMBOLS  = 16;
    localparam int Y_SYMBOLS  = 16;
    localparam int COUNT_BITS = 16;

    localparam int SYM_BITS    = 4;
    localparam int INFO_BITS   = 16;
    localparam int FRAC_BITS   = 10;
    localparam int MANT_BITS   = 32;

    localparam int JDEPTH      = X_SYMBOLS * Y_SYMBOLS;
    localparam int MDEPTH      = Y_SYMBOLS;
    localparam int JADDR_BITS  = $clog2(JDEPTH);
    localparam int MADDR_BITS  = $clog2(MDEPTH);
    localparam int EXP_BITS    = $clog2(COUNT_BITS);
    localparam int SHIFT_BITS  = $clog2(MANT_BITS);
    localparam int ITER_BITS   = $clog2(FRAC_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [INFO_BITS-1:0]  info_t;

    typedef enum logic
    {
        FUNC_COUNT = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_READ,
        ST_LOG,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== sv/pointwise_conditional_information.sv =====
// Pointwise conditional information estimator. Each request carries a pair
// (x,y) and a function in s_tuser: count adds one to the joint count of the
// pair and to the count of y, holding both and flagging saturated when either
// is already at its maximum; query returns log2(count_y) - log2(count_xy) in
// unsigned Q6.10, flagged valid_res only when the pair has been counted. The
// counts live in two RAMs with registered reads; both read as zero after
// reset. One request is in flight at a time: after acceptance it passes
// through the read state and, for a query of a seen pair, the log state,
// which waits on the ten serial squaring steps of the fixed-point log2 units;
// the done state then loads the output register once it is free and returns
// to idle, where the next request is accepted. A new request may be accepted
// while the previous result still waits on m_tready.
`default_nettype none

module pointwise_conditional_information (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // x_symbol[3:0], y_symbol[7:4]
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // info_bits[15:0]
    output logic      [1:0]  m_tuser    // valid_res[0], saturated[1]
);

    import pci_pkg::*;

    state_t                 state_reg, state_next;
    func_t                  func_reg, func_next;
    logic                   inrange_reg, inrange_next;
    logic [JADDR_BITS-1:0]  jaddr_reg, jaddr_next;
    logic [MADDR_BITS-1:0]  maddr_reg, maddr_next;
    logic                   jhit_reg, jhit_next;
    logic                   mhit_reg, mhit_next;
    logic [JDEPTH-1:0]      jvld_reg, jvld_next;
    logic [MDEPTH-1:0]      mvld_reg, mvld_next;

    info_t                  res_info_reg, res_info_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   res_sat_reg, res_sat_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    info_t                  m_info_reg, m_info_next;
    logic [1:0]             m_flags_reg, m_flags_next;

    logic [SYM_BITS-1:0]    x_sym, y_sym;
    logic                   in_range;
    logic [JADDR_BITS-1:0]  jaddr_in;
    logic [MADDR_BITS-1:0]  maddr_in;

    count_t                 jq, mq, cxy, cy;
    logic                   jwe, mwe;
    logic                   log_start;
    logic                   ly_done, lxy_done;
    info_t                  ly, lxy;

    assign x_sym    = s_tdata[SYM_BITS-1:0];
    assign y_sym    = s_tdata[2*SYM_BITS-1:SYM_BITS];
    assign in_range = (int'(x_sym) < X_SYMBOLS) && (int'(y_sym) < Y_SYMBOLS);
    assign jaddr_in = JADDR_BITS'(x_sym) * JADDR_BITS'(Y_SYMBOLS) + JADDR_BITS'(y_sym);
    assign maddr_in = MADDR_BITS'(y_sym);

    pci_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (JDEPTH)
    ) u_joint_ram (
        .clk   (clk),
        .we    (jwe),
        .waddr (jaddr_reg),
        .wdata (cxy + COUNT_BITS'(1)),
        .raddr (jaddr_in),
        .rdata (jq)
    );

    pci_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MDEPTH)
    ) u_marg_ram (
        .clk   (clk),
        .we    (mwe),
        .waddr (maddr_reg),
        .wdata (cy + COUNT_BITS'(1)),
        .raddr (maddr_in),
        .rdata (mq)
    );

    // entries never written read as zero
    assign cxy = jhit_reg ? jq : '0;
    assign cy  = mhit_reg ? mq : '0;

    pci_log2 u_log_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .n      (cy),
        .done   (ly_done),
        .result (ly)
    );

    pci_log2 u_log_xy (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .n      (cxy),
        .done   (lxy_done),
        .result (lxy)
    );

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        inrange_next   = inrange_reg;
        jaddr_next     = jaddr_reg;
        maddr_next     = maddr_reg;
        jhit_next      = jhit_reg;
        mhit_next      = mhit_reg;
        jvld_next      = jvld_reg;
        mvld_next      = mvld_reg;
        res_info_next  = res_info_reg;
        res_valid_next = res_valid_reg;
        res_sat_next   = res_sat_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_info_next    = m_info_reg;
        m_flags_next   = m_flags_reg;
        jwe            = 1'b0;
        mwe            = 1'b0;
        log_start      = 1'b0;
        s_tready       = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next    = func_t'(s_tuser);
                    inrange_next = in_range;
                    jaddr_next   = jaddr_in;
                    maddr_next   = maddr_in;
                    jhit_next    = jvld_reg[jaddr_in];
                    mhit_next    = mvld_reg[maddr_in];
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                res_info_next  = '0;
                res_valid_next = 1'b0;
                res_sat_next   = 1'b0;
                state_next     = ST_DONE;
                if (func_reg == FUNC_COUNT)
                begin
                    if (inrange_reg)
                    begin
                        if (cxy == COUNT_MAX || cy == COUNT_MAX)
                        begin
                            res_sat_next = 1'b1;
                        end
                        else
                        begin
                            jwe                  = 1'b1;
                            mwe                  = 1'b1;
                            jvld_next[jaddr_reg] = 1'b1;
                            mvld_next[maddr_reg] = 1'b1;
                        end
                    end
                end
                else if (inrange_reg && cxy != '0)
                begin
                    log_start  = 1'b1;
                    state_next = ST_LOG;
                end
            end
            ST_LOG:
            begin
                if (ly_done && lxy_done)
                begin
                    res_info_next  = (ly >= lxy) ? (ly - lxy) : '0;
                    res_valid_next = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_info_next   = res_info_reg;
                    m_flags_next  = {res_sat_reg, res_valid_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            jvld_reg     <= '0;
            mvld_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            jvld_reg     <= jvld_next;
            mvld_reg     <= mvld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        inrange_reg   <= inrange_next;
        jaddr_reg     <= jaddr_next;
        maddr_reg     <= maddr_next;
        jhit_reg      <= jhit_next;
        mhit_reg      <= mhit_next;
        res_info_reg  <= res_info_next;
        res_valid_reg <= res_valid_next;
        res_sat_reg   <= res_sat_next;
        m_info_reg    <= m_info_next;
        m_flags_reg   <= m_flags_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_info_reg;
    assign m_tuser  = m_flags_reg;

    // joint count of a pair can never exceed the count of its y symbol
    a_joint_le_marg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && inrange_reg) |-> (cxy <= cy))
        else $error("joint count exceeds marginal count");

    a_log_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ly_done || lxy_done) |-> (state_reg == ST_LOG && ly_done && lxy_done))
        else $error("log2 units out of step with control");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("valid_res and saturated both set");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("info_bits nonzero without valid_res");

    a_write_count_only: assert property (@(posedge clk) disable iff (!rst_n)
        (jwe || mwe) |-> (jwe && mwe && state_reg == ST_READ && func_reg == FUNC_COUNT))
        else $error("count RAM write outside a count request");

endmodule

`default_nettype wire

// ===== sv/pci_ram.sv =====
`default_nettype none

module pci_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/pci_log2.sv =====
`default_nettype none

module pci_log2 (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire pci_pkg::count_t n,
    output logic                done,
    output pci_pkg::info_t      result
);

    import pci_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [ITER_BITS-1:0]    iter_reg, iter_next;
    logic [EXP_BITS-1:0]     exp_reg, exp_next;
    logic [FRAC_BITS-1:0]    frac_reg, frac_next;
    logic [MANT_BITS-1:0]    mant_reg, mant_next;

    logic [EXP_BITS-1:0]     msb;
    logic [SHIFT_BITS-1:0]   shamt;
    logic [2*MANT_BITS-1:0]  prod;
    logic [MANT_BITS:0]      sq;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < COUNT_BITS; i++)
        begin
            if (n[i])
            begin
                msb = EXP_BITS'(i);
            end
        end
    end

    assign shamt = SHIFT_BITS'(MANT_BITS - 1) - SHIFT_BITS'(msb);
    assign prod  = (2*MANT_BITS)'(mant_reg) * (2*MANT_BITS)'(mant_reg);
    assign sq    = prod[2*MANT_BITS-1:MANT_BITS-1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        exp_next  = exp_reg;
        frac_next = frac_reg;
        mant_next = mant_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            exp_next  = msb;
            frac_next = '0;
            mant_next = MANT_BITS'(n) << shamt;
        end
        else if (busy_reg)
        begin
            // one squaring step per cycle yields one fraction bit
            frac_next = {frac_reg[FRAC_BITS-2:0], sq[MANT_BITS]};
            mant_next = sq[MANT_BITS] ? sq[MANT_BITS:1] : sq[MANT_BITS-1:0];
            iter_next = iter_reg + ITER_BITS'(1);
            if (iter_reg == ITER_BITS'(FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg  <= exp_next;
        frac_reg <= frac_next;
        mant_reg <= mant_next;
    end

    assign done   = done_reg;
    assign result = INFO_BITS'({exp_reg, frac_reg});

endmodule

`default_nettype wire
